// ===== design/pxf_pkg.sv =====
package pxf_pkg;

   // Table geometry.
   localparam int TABLE_ENTRIES = 128;
   localparam int TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TABLE_ENTRIES - 1);

   // Header hold buffer.
   localparam int HOLD_LEN = 42;
   localparam int HOLD_AW = 6;
   localparam logic [HOLD_AW-1:0] HOLD_FULL = HOLD_AW'(HOLD_LEN);

   // Command queue between the front and the back.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW = 2;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_ARP_WR = 2'd1;
   localparam logic [1:0] OP_FWD_WR = 2'd2;

   // Frame layout.
   localparam logic [15:0] ETYPE_ARP = 16'h0806;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [HOLD_AW-1:0] OFF_SRC = 6'd6;
   localparam logic [HOLD_AW-1:0] OFF_ETYPE = 6'd12;
   localparam logic [HOLD_AW-1:0] MIN_ETH = 6'd14;
   localparam logic [HOLD_AW-1:0] OFF_OPCODE = 6'd20;
   localparam logic [HOLD_AW-1:0] OFF_SHA = 6'd22;
   localparam logic [HOLD_AW-1:0] OFF_SPA = 6'd28;
   localparam logic [HOLD_AW-1:0] OFF_DIP = 6'd30;
   localparam logic [HOLD_AW-1:0] OFF_THA = 6'd32;
   localparam logic [HOLD_AW-1:0] MIN_IPV4 = 6'd34;
   localparam logic [HOLD_AW-1:0] OFF_TPA = 6'd38;
   localparam logic [HOLD_AW-1:0] MAC_LEN = 6'd6;
   localparam logic [HOLD_AW-1:0] IP_LEN = 6'd4;
   localparam logic [7:0] ARP_OP_REPLY = 8'h02;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_ARP_WR,
      KIND_FWD_WR
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] data_byte;
      logic last_byte;
      logic [TBL_AW-1:0] slot;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] port;
      logic valid;
   } cmd_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] port;
   } entry_type;

   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_ARP,
      MODE_FWD
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

// ===== design/pxf_front.sv =====
module pxf_front (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic [1:0] req_operation,
   input logic [7:0] req_data_byte,
   input logic req_last_byte,
   input logic [6:0] req_table_slot,
   input logic [31:0] req_entry_ip,
   input logic [47:0] req_entry_mac,
   input logic [15:0] req_entry_port,
   input logic req_entry_valid,
   input logic deq,
   output logic q_valid,
   output pxf_pkg::cmd_type q_cmd
);
   import pxf_pkg::*;

   cmd_type cmd;
   logic take;
   logic enq;
   logic [31:0] slot_ext;
   cmd_type q_mem [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0] count_ff, count_in;

   // Classify the incoming transaction; unused codes and slots beyond the table are dropped.
   always_comb begin
      slot_ext = 32'(req_table_slot);
      cmd.kind = KIND_BYTE;
      cmd.data_byte = req_data_byte;
      cmd.last_byte = req_last_byte;
      cmd.slot = slot_ext[TBL_AW-1:0];
      cmd.ip = req_entry_ip;
      cmd.mac = req_entry_mac;
      cmd.port = req_entry_port;
      cmd.valid = req_entry_valid;
      take = 1'b0;
      unique case (req_operation)
         OP_BYTE: begin
            cmd.kind = KIND_BYTE;
            take = 1'b1;
         end
         OP_ARP_WR: begin
            cmd.kind = KIND_ARP_WR;
            take = (slot_ext < 32'(TABLE_ENTRIES));
         end
         OP_FWD_WR: begin
            cmd.kind = KIND_FWD_WR;
            take = (slot_ext < 32'(TABLE_ENTRIES));
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   // Queue pointers and fill count.
   assign full = (count_ff == (Q_AW + 1)'(Q_DEPTH));
   assign enq = push && !full && take;
   assign q_valid = (count_ff != '0);
   assign q_cmd = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (Q_AW + 1)'(enq) - (Q_AW + 1)'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (enq) begin
         q_mem[wr_ptr_ff] <= cmd;
      end
   end

endmodule

// ===== design/pxf_back.sv =====
module pxf_back (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input pxf_pkg::cmd_type q_cmd,
   output logic deq,
   output logic empty,
   input logic pop,
   output logic [7:0] rsp_out_byte,
   output logic rsp_out_last,
   output logic rsp_verdict,
   output logic [15:0] rsp_egress_port
);
   import pxf_pkg::*;

   // Byte j of a MAC, first wire byte first.
   function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [HOLD_AW-1:0] j);
      logic [47:0] sh;
      sh = mac << {j[2:0], 3'b000};
      return sh[47:40];
   endfunction

   // Hold buffer address that supplies output byte i.
   function automatic logic [HOLD_AW-1:0] src_addr(input mode_type m,
                                                    input logic [HOLD_AW-1:0] i);
      logic [HOLD_AW-1:0] a;
      a = i;
      if (m == MODE_ARP) begin
         if (i < MAC_LEN) begin
            a = i + OFF_SRC;
         end else if (i >= OFF_SPA && i < OFF_SPA + IP_LEN) begin
            a = i - OFF_SPA + OFF_TPA;
         end else if (i >= OFF_THA && i < OFF_TPA) begin
            a = i - OFF_THA + OFF_SRC;
         end else if (i >= OFF_TPA) begin
            a = i - OFF_TPA + OFF_SPA;
         end
      end
      return a;
   endfunction

   // Final value of output byte i.
   function automatic logic [7:0] out_sel(input mode_type m, input logic [HOLD_AW-1:0] i,
                                          input logic [7:0] held, input logic [47:0] mac);
      logic [7:0] b;
      b = held;
      if (m == MODE_ARP) begin
         if (i >= OFF_SRC && i < OFF_SRC + MAC_LEN) begin
            b = mac_byte(mac, i - OFF_SRC);
         end else if (i == OFF_OPCODE) begin
            b = 8'h00;
         end else if (i == OFF_OPCODE + 1'b1) begin
            b = ARP_OP_REPLY;
         end else if (i >= OFF_SHA && i < OFF_SPA) begin
            b = mac_byte(mac, i - OFF_SHA);
         end
      end else if (m == MODE_FWD) begin
         if (i < MAC_LEN) begin
            b = mac_byte(mac, i);
         end
      end
      return b;
   endfunction

   state_type state_ff, state_in;
   logic [HOLD_AW-1:0] cnt_ff, cnt_in;
   logic [15:0] etype_ff, etype_in;
   logic [31:0] sip_ff, sip_in;
   logic [31:0] dip_ff, dip_in;
   logic [HOLD_AW-1:0] n_ff, n_in;
   logic flast_ff, flast_in;
   logic [HOLD_AW-1:0] ei_ff, ei_in;
   logic verdict_ff, verdict_in;
   logic [15:0] port_ff, port_in;
   logic [47:0] mac_ff, mac_in;
   mode_type mode_ff, mode_in;
   logic use_arp_ff, use_arp_in;
   logic [31:0] key_ff, key_in;
   logic [TBL_AW-1:0] sc_ff, sc_in;
   logic pv_ff, pv_in;
   logic [TBL_AW-1:0] pidx_ff, pidx_in;
   logic pvld_ff, pvld_in;
   logic ov_ff, ov_in;
   logic [7:0] ob_ff, ob_in;
   logic ol_ff, ol_in;
   logic overd_ff, overd_in;
   logic [15:0] oport_ff, oport_in;

   entry_type arp_mem [TABLE_ENTRIES];
   entry_type fwd_mem [TABLE_ENTRIES];
   logic arp_vld_ff [TABLE_ENTRIES];
   logic fwd_vld_ff [TABLE_ENTRIES];
   entry_type arp_rd_ff, fwd_rd_ff, rd_entry;
   logic [7:0] hold_mem [HOLD_LEN];
   logic [7:0] hold_rd_ff;
   logic [HOLD_AW-1:0] hold_raddr;
   logic arp_we, fwd_we, hold_we;
   logic out_free, hit, last_out;
   entry_type wr_entry;

   assign empty = !ov_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_out_last = ol_ff;
   assign rsp_verdict = overd_ff;
   assign rsp_egress_port = oport_ff;

   assign out_free = !ov_ff || pop;
   assign rd_entry = use_arp_ff ? arp_rd_ff : fwd_rd_ff;
   assign hold_raddr = src_addr(mode_ff, ei_ff);
   assign wr_entry = '{ip: q_cmd.ip, mac: q_cmd.mac, port: q_cmd.port};

   // Sequencer: table writes, header hold, table search, header burst and byte pass-through.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      etype_in = etype_ff;
      sip_in = sip_ff;
      dip_in = dip_ff;
      n_in = n_ff;
      flast_in = flast_ff;
      ei_in = ei_ff;
      verdict_in = verdict_ff;
      port_in = port_ff;
      mac_in = mac_ff;
      mode_in = mode_ff;
      use_arp_in = use_arp_ff;
      key_in = key_ff;
      sc_in = sc_ff;
      pv_in = pv_ff;
      pidx_in = pidx_ff;
      pvld_in = pvld_ff;
      ov_in = ov_ff && !pop;
      ob_in = ob_ff;
      ol_in = ol_ff;
      overd_in = overd_ff;
      oport_in = oport_ff;
      deq = 1'b0;
      arp_we = 1'b0;
      fwd_we = 1'b0;
      hold_we = 1'b0;
      hit = 1'b0;
      last_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  KIND_ARP_WR: begin
                     deq = 1'b1;
                     arp_we = 1'b1;
                  end
                  KIND_FWD_WR: begin
                     deq = 1'b1;
                     fwd_we = 1'b1;
                  end
                  KIND_BYTE: begin
                     if (cnt_ff == HOLD_FULL) begin
                        // Header already sent: the byte passes straight through.
                        if (out_free) begin
                           deq = 1'b1;
                           ov_in = 1'b1;
                           ob_in = q_cmd.data_byte;
                           ol_in = q_cmd.last_byte;
                           overd_in = q_cmd.last_byte && verdict_ff;
                           oport_in = (q_cmd.last_byte && verdict_ff) ? port_ff : 16'h0;
                           if (q_cmd.last_byte) begin
                              cnt_in = '0;
                           end
                        end
                     end else begin
                        deq = 1'b1;
                        hold_we = 1'b1;
                        cnt_in = cnt_ff + 1'b1;
                        if (cnt_ff == OFF_ETYPE) begin
                           etype_in[15:8] = q_cmd.data_byte;
                        end
                        if (cnt_ff == OFF_ETYPE + 1'b1) begin
                           etype_in[7:0] = q_cmd.data_byte;
                        end
                        if (cnt_ff >= OFF_SPA && cnt_ff < OFF_SPA + IP_LEN) begin
                           sip_in = {sip_ff[23:0], q_cmd.data_byte};
                        end
                        if (cnt_ff >= OFF_DIP && cnt_ff < OFF_DIP + IP_LEN) begin
                           dip_in = {dip_ff[23:0], q_cmd.data_byte};
                        end
                        if (cnt_in == HOLD_FULL || q_cmd.last_byte) begin
                           // Header complete or frame ended: decide what to search.
                           n_in = cnt_in;
                           flast_in = q_cmd.last_byte;
                           ei_in = '0;
                           verdict_in = 1'b0;
                           port_in = 16'h0;
                           mode_in = MODE_PASS;
                           sc_in = '0;
                           pv_in = 1'b0;
                           state_in = ST_READ;
                           if (cnt_in >= MIN_ETH) begin
                              if (etype_in == ETYPE_ARP) begin
                                 if (cnt_in == HOLD_FULL) begin
                                    use_arp_in = 1'b1;
                                    key_in = sip_in;
                                    state_in = ST_SCAN;
                                 end
                              end else if (etype_in == ETYPE_IPV4 && cnt_in >= MIN_IPV4) begin
                                 use_arp_in = 1'b0;
                                 key_in = dip_in;
                                 state_in = ST_SCAN;
                              end
                           end
                        end
                     end
                  end
                  default: begin
                     deq = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // One entry per cycle, lowest slot first; read data comes from a registered read port.
            hit = pv_ff && pvld_ff && (rd_entry.ip == key_ff);
            if (hit) begin
               verdict_in = 1'b1;
               port_in = rd_entry.port;
               mac_in = rd_entry.mac;
               mode_in = use_arp_ff ? MODE_ARP : MODE_FWD;
               state_in = ST_READ;
            end else if (pv_ff && pidx_ff == TBL_LAST) begin
               mode_in = MODE_PASS;
               state_in = ST_READ;
            end else begin
               sc_in = sc_ff + 1'b1;
               pv_in = 1'b1;
               pidx_in = sc_ff;
               pvld_in = use_arp_ff ? arp_vld_ff[sc_ff] : fwd_vld_ff[sc_ff];
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            // Hand one header byte to the result register.
            if (out_free) begin
               last_out = flast_ff && (ei_ff == n_ff - 1'b1);
               ov_in = 1'b1;
               ob_in = out_sel(mode_ff, ei_ff, hold_rd_ff, mac_ff);
               ol_in = last_out;
               overd_in = last_out && verdict_ff;
               oport_in = (last_out && verdict_ff) ? port_ff : 16'h0;
               if (ei_ff == n_ff - 1'b1) begin
                  state_in = ST_IDLE;
                  if (flast_ff) begin
                     cnt_in = '0;
                  end
               end else begin
                  ei_in = ei_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         verdict_ff <= 1'b0;
         port_ff <= 16'h0;
         mode_ff <= MODE_PASS;
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         verdict_ff <= verdict_in;
         port_ff <= port_in;
         mode_ff <= mode_in;
         pv_ff <= pv_in;
         ov_ff <= ov_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      etype_ff <= etype_in;
      sip_ff <= sip_in;
      dip_ff <= dip_in;
      n_ff <= n_in;
      flast_ff <= flast_in;
      ei_ff <= ei_in;
      mac_ff <= mac_in;
      use_arp_ff <= use_arp_in;
      key_ff <= key_in;
      sc_ff <= sc_in;
      pidx_ff <= pidx_in;
      pvld_ff <= pvld_in;
      ob_ff <= ob_in;
      ol_ff <= ol_in;
      overd_ff <= overd_in;
      oport_ff <= oport_in;
   end

   // Entry valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TABLE_ENTRIES; k++) begin
            arp_vld_ff[k] <= 1'b0;
            fwd_vld_ff[k] <= 1'b0;
         end
      end else begin
         if (arp_we) begin
            arp_vld_ff[q_cmd.slot] <= q_cmd.valid;
         end
         if (fwd_we) begin
            fwd_vld_ff[q_cmd.slot] <= q_cmd.valid;
         end
      end
   end

   // Table memories: one write port, one registered read port at the search index.
   always_ff @(posedge clock) begin
      if (arp_we) begin
         arp_mem[q_cmd.slot] <= wr_entry;
      end
      arp_rd_ff <= arp_mem[sc_ff];
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[q_cmd.slot] <= wr_entry;
      end
      fwd_rd_ff <= fwd_mem[sc_ff];
   end

   // Header hold memory.
   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[cnt_ff] <= q_cmd.data_byte;
      end
      hold_rd_ff <= hold_mem[hold_raddr];
   end

endmodule

// ===== design/proxy_arp_and_ip_forwarder.sv =====
// The command queue registers each accepted transaction. When the back takes it, a table
// write lands, or a byte after the 42nd is loaded into the result register.
// Transactions flow at one per cycle while the result register is free, except at a header's
// end: the back scans the table, then sends each held byte through ST_READ and ST_SEND.
// Reset is synchronous: it empties the queue, the result register and both tables.
module proxy_arp_and_ip_forwarder (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic [1:0] req_operation,
   input logic [7:0] req_data_byte,
   input logic req_last_byte,
   input logic [6:0] req_table_slot,
   input logic [31:0] req_entry_ip,
   input logic [47:0] req_entry_mac,
   input logic [15:0] req_entry_port,
   input logic req_entry_valid,
   output logic empty,
   input logic pop,
   output logic [7:0] rsp_out_byte,
   output logic rsp_out_last,
   output logic rsp_verdict,
   output logic [15:0] rsp_egress_port
);
   import pxf_pkg::*;

   logic q_valid;
   logic deq;
   cmd_type q_cmd;

   // Front: classification and command queue.
   pxf_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_operation(req_operation),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .req_table_slot(req_table_slot),
      .req_entry_ip(req_entry_ip),
      .req_entry_mac(req_entry_mac),
      .req_entry_port(req_entry_port),
      .req_entry_valid(req_entry_valid),
      .deq(deq),
      .q_valid(q_valid),
      .q_cmd(q_cmd)
   );

   // Back: tables, header hold, search and rewrite.
   pxf_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .deq(deq),
      .empty(empty),
      .pop(pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_last(rsp_out_last),
      .rsp_verdict(rsp_verdict),
      .rsp_egress_port(rsp_egress_port)
   );

endmodule
